@@ rtl/dtp_pkg.sv @@
package dtp_pkg;

   // Command codes carried on the request channel
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   // Register select codes
   typedef enum logic [1:0] {
      REG_DIV  = 2'd0,
      REG_TIMA = 2'd1,
      REG_TMA  = 2'd2,
      REG_TAC  = 2'd3
   } reg_sel_type;

   localparam int DIV_WIDTH  = 16;
   localparam int TAP_WIDTH  = 10;
   localparam int DATA_WIDTH = 8;

   localparam logic [DIV_WIDTH-1:0] DIV_STEP   = 16'h0004;
   localparam logic [TAP_WIDTH-1:0] TAP_RESET  = 10'h200;
   localparam int                   TAC_ENABLE = 2;

   // One request beat as held in the input register
   typedef struct packed {
      cmd_type                 cmd;
      reg_sel_type             reg_sel;
      logic [DATA_WIDTH-1:0]   wdata;
   } req_beat_type;

   // One response beat
   typedef struct packed {
      logic [DATA_WIDTH-1:0]   rdata;
      logic                    timer_irq;
   } rsp_beat_type;

   // Divider bit watched for each TAC clock select
   function automatic logic [TAP_WIDTH-1:0] tap_select(input logic [1:0] clk_sel);
      logic [TAP_WIDTH-1:0] mask;
      case (clk_sel)
         2'd0:    mask = 10'h200;
         2'd1:    mask = 10'h008;
         2'd2:    mask = 10'h020;
         default: mask = 10'h080;
      endcase
      return mask;
   endfunction

endpackage

@@ rtl/dtp_in_stage.sv @@
module dtp_in_stage
   import dtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [1:0]            req_reg_sel,
   input  logic [DATA_WIDTH-1:0] req_wdata,
   input  logic                  take,
   output logic                  beat_valid,
   output req_beat_type          beat
);

   logic         valid_ff, valid_in;
   req_beat_type beat_ff;

   // Stage is free when empty or when its beat moves on this cycle
   assign req_ready  = !valid_ff || take;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload capture, no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         beat_ff.cmd     <= cmd_type'(req_cmd);
         beat_ff.reg_sel <= reg_sel_type'(req_reg_sel);
         beat_ff.wdata   <= req_wdata;
      end
   end

endmodule

@@ rtl/dtp_core.sv @@
module dtp_core
   import dtp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_beat_type beat,
   output rsp_beat_type result
);

   logic [DIV_WIDTH-1:0]  div_count_ff,  div_count_in;
   logic [DATA_WIDTH-1:0] div_byte_ff,   div_byte_in;
   logic [DATA_WIDTH-1:0] tima_ff,       tima_in;
   logic [DATA_WIDTH-1:0] tma_ff,        tma_in;
   logic [DATA_WIDTH-1:0] tac_ff,        tac_in;
   logic [TAP_WIDTH-1:0]  tap_mask_ff,   tap_mask_in;
   logic                  last_tap_ff,   last_tap_in;
   logic                  ovf_pend_ff,   ovf_pend_in;

   logic [DIV_WIDTH-1:0]  div_step;
   logic [DATA_WIDTH-1:0] tima_base;
   logic [DATA_WIDTH-1:0] tima_inc;
   logic                  tap_now;

   // Tick datapath pieces
   assign div_step  = div_count_ff + DIV_STEP;
   assign tap_now   = |(div_step[TAP_WIDTH-1:0] & tap_mask_ff);
   assign tima_base = ovf_pend_ff ? tma_ff : tima_ff;
   assign tima_inc  = tima_base + 8'd1;

   // Next state and response for the beat in the input register
   always_comb begin
      div_count_in     = div_count_ff;
      div_byte_in      = div_byte_ff;
      tima_in          = tima_ff;
      tma_in           = tma_ff;
      tac_in           = tac_ff;
      tap_mask_in      = tap_mask_ff;
      last_tap_in      = last_tap_ff;
      ovf_pend_in      = ovf_pend_ff;
      result.rdata     = '0;
      result.timer_irq = 1'b0;

      unique case (beat.cmd)
         CMD_TICK: begin
            result.timer_irq = ovf_pend_ff;
            ovf_pend_in      = 1'b0;
            tima_in          = tima_base;
            div_count_in     = div_step;
            div_byte_in      = div_step[DIV_WIDTH-1 -: DATA_WIDTH];
            if (tac_ff[TAC_ENABLE]) begin
               // falling edge of the tapped divider bit
               if (last_tap_ff && !tap_now) begin
                  tima_in = tima_inc;
                  if (tima_inc == '0) begin
                     ovf_pend_in = 1'b1;
                  end
               end
               last_tap_in = tap_now;
            end
         end
         CMD_READ: begin
            unique case (beat.reg_sel)
               REG_DIV:  result.rdata = div_byte_ff;
               REG_TIMA: result.rdata = tima_ff;
               REG_TMA:  result.rdata = tma_ff;
               REG_TAC:  result.rdata = tac_ff;
               default:  result.rdata = '0;
            endcase
         end
         CMD_WRITE: begin
            unique case (beat.reg_sel)
               REG_DIV:  div_count_in = '0;
               REG_TIMA: tima_in      = beat.wdata;
               REG_TMA:  tma_in       = beat.wdata;
               REG_TAC: begin
                  tac_in      = beat.wdata;
                  tap_mask_in = tap_select(beat.wdata[1:0]);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Timer state, updated once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         div_count_ff <= '0;
         div_byte_ff  <= '0;
         tima_ff      <= '0;
         tma_ff       <= '0;
         tac_ff       <= '0;
         tap_mask_ff  <= TAP_RESET;
         last_tap_ff  <= 1'b0;
         ovf_pend_ff  <= 1'b0;
      end else if (fire) begin
         div_count_ff <= div_count_in;
         div_byte_ff  <= div_byte_in;
         tima_ff      <= tima_in;
         tma_ff       <= tma_in;
         tac_ff       <= tac_in;
         tap_mask_ff  <= tap_mask_in;
         last_tap_ff  <= last_tap_in;
         ovf_pend_ff  <= ovf_pend_in;
      end
   end

endmodule

@@ rtl/dtp_out_stage.sv @@
module dtp_out_stage
   import dtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat_valid,
   input  rsp_beat_type          result,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_rdata,
   output logic                  rsp_timer_irq
);

   logic         valid_ff, valid_in;
   rsp_beat_type result_ff;

   // Result register may reload when empty or being drained
   assign take          = !valid_ff || rsp_ready;
   assign valid_in      = take ? beat_valid : valid_ff;
   assign rsp_valid     = valid_ff;
   assign rsp_rdata     = result_ff.rdata;
   assign rsp_timer_irq = result_ff.timer_irq;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && beat_valid) begin
         result_ff <= result;
      end
   end

endmodule

@@ rtl/divider_timer_peripheral_unit.sv @@
// Channel   Ports                                   Direction
// req       req_valid/ready, cmd, reg_sel, wdata    in   (tick, read, write)
// rsp       rsp_valid/ready, rdata, timer_irq       out  (one beat per req beat)
//
// One response beat per request beat, passing the input register,
// combinational timer update logic, then the result register. Throughput is
// one beat per clock while the rsp channel is not stalled.
// Synchronous active-high reset clears both stage valids and resets all timer state.
// A stalled rsp channel holds the result; req_ready drops only when both
// registers are full and rsp_ready is low.
module divider_timer_peripheral_unit
   import dtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [1:0]            req_reg_sel,
   input  logic [DATA_WIDTH-1:0] req_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_rdata,
   output logic                  rsp_timer_irq
);

   logic         take;
   logic         beat_valid;
   req_beat_type beat;
   rsp_beat_type result;

   dtp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_reg_sel (req_reg_sel),
      .req_wdata   (req_wdata),
      .take        (take),
      .beat_valid  (beat_valid),
      .beat        (beat)
   );

   // State commits exactly when the beat moves into the result register
   dtp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (beat_valid && take),
      .beat   (beat),
      .result (result)
   );

   dtp_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .beat_valid    (beat_valid),
      .result        (result),
      .take          (take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rdata     (rsp_rdata),
      .rsp_timer_irq (rsp_timer_irq)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import dtp_pkg::*;

   // Command code 3 has no meaning; the timer must ignore it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int PHASE_BEATS  = 192;
   localparam int LONG_HOLD    = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DIR_ROWS     = 34;

   // Divider bit watched for each TAC clock select
   localparam logic [TAP_WIDTH-1:0] TAP_MASKS [4] = '{10'h200, 10'h008, 10'h020, 10'h080};

   typedef struct {
      logic [1:0] cmd;
      logic [1:0] sel;
      logic [7:0] wdata;
      int         reps;
      bit         fixed;
      logic [7:0] rdata;
      logic       irq;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_cmd = 2'd0;
   logic [1:0]            req_reg_sel = 2'd0;
   logic [DATA_WIDTH-1:0] req_wdata = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_WIDTH-1:0] rsp_rdata;
   logic                  rsp_timer_irq;

   divider_timer_peripheral_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_reg_sel   (req_reg_sel),
      .req_wdata     (req_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rdata     (rsp_rdata),
      .rsp_timer_irq (rsp_timer_irq)
   );

   // Clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Predicted timer state
   logic [DIV_WIDTH-1:0]  div_count;
   logic [7:0]            div_shown;
   logic [7:0]            tima;
   logic [7:0]            tma;
   logic [7:0]            tac;
   logic [TAP_WIDTH-1:0]  tap_mask;
   logic                  tap_last;
   logic                  reload_due;

   rsp_beat_type expected_rsp [$];
   stim_row_type dir_rows [DIR_ROWS];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_req = 1'b0;
   int  fails = 0;
   int  cycles = 0;
   int  n_tick = 0;
   int  n_read = 0;
   int  n_write = 0;
   int  n_unused = 0;
   int  n_irq = 0;
   int  n_checked = 0;

   // Advance the predicted timer by one request beat and return its response
   function automatic rsp_beat_type timer_step(input logic [1:0] cmd, input logic [1:0] sel,
                                               input logic [7:0] wdata);
      rsp_beat_type r;
      logic         tap_now;
      r = '0;
      case (cmd)
         CMD_TICK: begin
            // pending overflow reloads before the divider moves
            if (reload_due) begin
               reload_due  = 1'b0;
               tima        = tma;
               r.timer_irq = 1'b1;
            end
            div_count = div_count + DIV_STEP;
            div_shown = div_count[15:8];
            // falling edge of the tapped bit counts, only while enabled
            if (tac[TAC_ENABLE]) begin
               tap_now = |(div_count[TAP_WIDTH-1:0] & tap_mask);
               if (tap_last && !tap_now) begin
                  tima = tima + 8'd1;
                  if (tima == 8'd0)
                     reload_due = 1'b1;
               end
               tap_last = tap_now;
            end
         end
         CMD_READ: begin
            case (sel)
               REG_DIV:  r.rdata = div_shown;
               REG_TIMA: r.rdata = tima;
               REG_TMA:  r.rdata = tma;
               default:  r.rdata = tac;
            endcase
         end
         CMD_WRITE: begin
            case (sel)
               REG_DIV:  div_count = '0;
               REG_TIMA: tima = wdata;
               REG_TMA:  tma = wdata;
               default: begin
                  tac      = wdata;
                  tap_mask = TAP_MASKS[wdata[1:0]];
               end
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one request beat, waiting out random gaps, then record its expectation
   task automatic send_beat(input logic [1:0] cmd, input logic [1:0] sel,
                            input logic [7:0] wdata, input bit fixed,
                            input rsp_beat_type fixed_rsp);
      rsp_beat_type predicted;
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_reg_sel <= sel;
      req_wdata   <= wdata;
      do @(posedge clock); while (!req_ready);
      predicted = timer_step(cmd, sel, wdata);
      expected_rsp.push_back(fixed ? fixed_rsp : predicted);
      case (cmd)
         CMD_TICK:  n_tick++;
         CMD_READ:  n_read++;
         CMD_WRITE: n_write++;
         default:   n_unused++;
      endcase
      if (predicted.timer_irq)
         n_irq++;
   endtask

   // Random beat: mostly ticks, with register traffic biased towards overflows
   task automatic random_beat();
      int          pick;
      logic [1:0]  cmd;
      logic [1:0]  sel;
      logic [7:0]  wdata;
      pick  = $urandom_range(99);
      sel   = 2'($urandom_range(3));
      wdata = 8'($urandom_range(255));
      if (pick < 62)
         cmd = CMD_TICK;
      else if (pick < 78)
         cmd = CMD_READ;
      else if (pick < 96) begin
         cmd = CMD_WRITE;
         case (sel)
            REG_TAC: begin
               if ($urandom_range(99) < 80)
                  wdata[TAC_ENABLE] = 1'b1;
               if ($urandom_range(99) < 50)
                  wdata[1:0] = 2'd1;
            end
            REG_TMA, REG_TIMA: begin
               if ($urandom_range(99) < 60)
                  wdata = 8'($urandom_range(255, 240));
            end
            default: ;
         endcase
      end else
         cmd = CMD_UNUSED;
      send_beat(cmd, sel, wdata, 1'b0, '0);
   endtask

   // Drop valid and wait until every expected response beat has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // Compare one accepted response beat with the oldest expectation
   task automatic check_rsp();
      rsp_beat_type want;
      if (expected_rsp.size() == 0) begin
         $error("response beat with nothing expected: rdata=%0h timer_irq=%0b",
                rsp_rdata, rsp_timer_irq);
         fails++;
      end else begin
         want = expected_rsp.pop_front();
         n_checked++;
         if (rsp_rdata !== want.rdata) begin
            $error("rdata: expected %0h, got %0h", want.rdata, rsp_rdata);
            fails++;
         end
         if (rsp_timer_irq !== want.timer_irq) begin
            $error("timer_irq: expected %0b, got %0b", want.timer_irq, rsp_timer_irq);
            fails++;
         end
      end
   endtask

   // Response side: random back-pressure plus one long hold on request
   initial begin
      int hold_left;
      hold_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            check_rsp();
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Stimulus
   initial begin
      rsp_beat_type fixed_rsp;
      div_count  = '0;
      div_shown  = '0;
      tima       = '0;
      tma        = '0;
      tac        = '0;
      tap_mask   = TAP_RESET;
      tap_last   = 1'b0;
      reload_due = 1'b0;

      // Directed beats: reset values, extremes, disabled timer, ignored command,
      // divider clear, counter write while a reload is pending, carry into DIV
      dir_rows = '{
         '{CMD_READ,   REG_DIV,  8'h00, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_READ,   REG_TIMA, 8'h00, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_READ,   REG_TMA,  8'h00, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_READ,   REG_TAC,  8'h00, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_WRITE,  REG_TMA,  8'hFF, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_READ,   REG_TMA,  8'h00, 1,     1'b1, 8'hFF, 1'b0},
         '{CMD_WRITE,  REG_TAC,  8'hFF, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_READ,   REG_TAC,  8'h00, 1,     1'b1, 8'hFF, 1'b0},
         '{CMD_WRITE,  REG_TIMA, 8'hFE, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_WRITE,  REG_TAC,  8'h05, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 12,    1'b0, 8'h00, 1'b0},
         '{CMD_READ,   REG_TIMA, 8'h00, 1,     1'b0, 8'h00, 1'b0},
         '{CMD_WRITE,  REG_DIV,  8'hAB, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_READ,   REG_DIV,  8'h00, 1,     1'b0, 8'h00, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 1,     1'b0, 8'h00, 1'b0},
         '{CMD_READ,   REG_DIV,  8'h00, 1,     1'b0, 8'h00, 1'b0},
         '{CMD_UNUSED, REG_TAC,  8'hFF, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_UNUSED, REG_DIV,  8'h00, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_WRITE,  REG_TAC,  8'h02, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 4,     1'b0, 8'h00, 1'b0},
         '{CMD_READ,   REG_TIMA, 8'h00, 1,     1'b0, 8'h00, 1'b0},
         '{CMD_WRITE,  REG_DIV,  8'h00, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_WRITE,  REG_TAC,  8'h05, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 1,     1'b0, 8'h00, 1'b0},
         '{CMD_WRITE,  REG_TIMA, 8'hFF, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 3,     1'b0, 8'h00, 1'b0},
         '{CMD_WRITE,  REG_TIMA, 8'h42, 1,     1'b1, 8'h00, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 1,     1'b1, 8'h00, 1'b1},
         '{CMD_READ,   REG_TIMA, 8'h00, 1,     1'b1, 8'hFF, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 70,    1'b0, 8'h00, 1'b0},
         '{CMD_READ,   REG_DIV,  8'h00, 1,     1'b0, 8'h00, 1'b0},
         '{CMD_TICK,   REG_DIV,  8'h00, 8,     1'b0, 8'h00, 1'b0},
         '{CMD_READ,   REG_DIV,  8'h00, 1,     1'b0, 8'h00, 1'b0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         fixed_rsp.rdata     = dir_rows[i].rdata;
         fixed_rsp.timer_irq = dir_rows[i].irq;
         for (int k = 0; k < dir_rows[i].reps; k++)
            send_beat(dir_rows[i].cmd, dir_rows[i].sel, dir_rows[i].wdata,
                      dir_rows[i].fixed, fixed_rsp);
      end
      wait_drained();

      // Random phases: receiver-light, sender-light, then full rate with a long hold
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 35; recv_idle_pct = 79; end
            1: begin send_idle_pct = 79; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (phase == 2 && i == 40)
               hold_req = 1'b1;
            random_beat();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d ticks, %0d reads, %0d writes, %0d ignored commands",
               n_tick, n_read, n_write, n_unused);
      $display("%0d response beats compared, %0d timer interrupts predicted", n_checked, n_irq);
      if (fails == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dtp_pkg.sv
rtl/dtp_in_stage.sv
rtl/dtp_core.sv
rtl/dtp_out_stage.sv
rtl/divider_timer_peripheral_unit.sv
tb/tb_top.sv
